FILE: design/ssfc_pkg.sv
`timescale 1ns / 1ps
package ssfc_pkg;
  localparam logic [1:0] FMT_IBM  = 2'd0;
  localparam logic [1:0] FMT_IEEE = 2'd1;
  localparam logic [1:0] FMT_AUTO = 2'd2;
  localparam logic [1:0] FMT_RESET = FMT_IEEE;
  localparam int WORD_W = 32;
  localparam int IBM_BIAS = 64;

  typedef struct packed {
    logic        valid;
    logic        action;
    logic        conv;
    logic [31:0] word;
  } stage_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [4:0] msb24(input logic [23:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) p = i[4:0];
    end
    msb24 = p;
  endfunction
endpackage

FILE: design/ssfc_core.sv
`timescale 1ns / 1ps
module ssfc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  ssfc_pkg::stage_t      in_stage,
  output logic                  out_valid,
  output logic [31:0]           out_word,
  output logic                  out_special
);
  // stage 1: classify and find leading one
  ssfc_pkg::stage_t s1;
  logic [4:0]  s1_p;
  logic [23:0] s1_frac;
  logic        s1_zero, s1_spec;

  logic [23:0] c_frac;
  logic        c_zero, c_spec;
  logic [7:0]  c_e8;
  logic [22:0] c_s;
  always_comb begin
    c_e8 = in_stage.word[30:23];
    c_s  = in_stage.word[22:0];
    c_spec = 1'b0;
    if (!in_stage.action) begin
      c_frac = in_stage.word[23:0];
      c_zero = (c_frac == 24'd0);
    end else begin
      c_spec = (c_e8 == 8'hFF);
      c_zero = (c_e8 == 8'd0) && (c_s == 23'd0);
      c_frac = (c_e8 == 8'd0) ? {1'b0, c_s} : {1'b1, c_s};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= in_stage.valid;
    end
    s1.action <= in_stage.action;
    s1.conv   <= in_stage.conv;
    s1.word   <= in_stage.word;
    s1_frac   <= c_frac;
    s1_zero   <= c_zero;
    s1_spec   <= c_spec;
    s1_p      <= ssfc_pkg::msb24(c_frac);
  end

  // stage 2: exponent math and shift amounts
  ssfc_pkg::stage_t s2;
  logic [23:0] s2_frac;
  logic        s2_zero, s2_spec, s2_norm, s2_ovf, s2_left, s2_flush;
  logic [7:0]  s2_exp;
  logic [5:0]  s2_sh;

  logic signed [10:0] b, sd, q, t;
  logic signed [10:0] k;
  logic [6:0] e7;
  always_comb begin
    e7 = s1.word[30:24];
    b  = $signed({6'd0, s1_p}) + 11'sd4 * $signed({4'd0, e7}) - 11'sd153;
    sd = 11'sd4 * $signed({4'd0, e7}) - 11'sd131;
    q  = ((s1.word[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, s1.word[30:23]})) - 11'sd150;
    // floor((p + q) / 4) + 1 keeps the sum inside the signed range
    k  = (($signed({6'd0, s1_p}) + q) >>> 2) + 11'sd1;
    t  = q + 11'sd24 - (k <<< 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
    end
    s2.action <= s1.action;
    s2.conv   <= s1.conv;
    s2.word   <= s1.word;
    s2_frac   <= s1_frac;
    s2_zero   <= s1_zero;
    s2_spec   <= s1_spec;
    if (!s1.action) begin
      s2_ovf   <= (b >= 11'sd255);
      s2_norm  <= (b >= 11'sd1);
      s2_exp   <= b[7:0];
      s2_left  <= (b >= 11'sd1) ? 1'b1 : (sd >= 11'sd0);
      s2_flush <= (sd <= -11'sd32);
      s2_sh    <= (b >= 11'sd1) ? 6'(5'd23 - s1_p) :
                  (sd >= 11'sd0) ? sd[5:0] : 6'(-sd);
    end else begin
      s2_ovf   <= 1'b0;
      s2_norm  <= 1'b0;
      s2_exp   <= 8'(k + 11'sd64);
      s2_left  <= (t >= 11'sd0);
      s2_flush <= 1'b0;
      s2_sh    <= (t >= 11'sd0) ? t[5:0] : 6'(-t);
    end
  end

  // stage 3: shift, round, assemble
  logic [31:0] r;
  logic        spec;
  logic [31:0] v, m, rem, half, sh_l, sh_r;
  always_comb begin
    v    = {8'd0, s2_frac};
    sh_l = (s2_sh >= 6'd32) ? 32'd0 : v << s2_sh[4:0];
    sh_r = (s2_sh >= 6'd32) ? 32'd0 : v >> s2_sh[4:0];
    rem  = v & ((32'd1 << s2_sh[4:0]) - 32'd1);
    half = 32'd1 << (s2_sh[4:0] - 5'd1);
    m    = sh_r;
    if ((rem > half) || ((rem == half) && m[0])) m = m + 32'd1;
    spec = 1'b0;
    if (!s2.conv) begin
      r = s2.word;
    end else if (!s2.action) begin
      if (s2_zero)       r = {s2.word[31], 31'd0};
      else if (s2_ovf)   r = {s2.word[31], 8'hFF, 23'd0};
      else if (s2_norm)  r = {s2.word[31], s2_exp, sh_l[22:0]};
      else if (s2_left)  r = {s2.word[31], sh_l[30:0]};
      else if (s2_flush) r = {s2.word[31], 31'd0};
      else               r = {s2.word[31], m[30:0]};
    end else begin
      if (s2_spec) begin
        spec = 1'b1;
        r = {s2.word[31], 31'h7FFFFFFF};
      end else if (s2_zero) begin
        r = 32'd0;
      end else begin
        r = {s2.word[31], s2_exp[6:0], (s2_left ? sh_l[23:0] : sh_r[23:0])};
      end
    end
    if (s2.action) r = ssfc_pkg::swap32(r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2.valid;
    end
    out_word    <= r;
    out_special <= spec && s2.valid;
  end
endmodule

FILE: design/seismic_sample_format_converter_unit.sv
`timescale 1ns / 1ps
// Channel     | Signals                          | Handshake
// ------------+----------------------------------+---------------------------
// command     | start, busy, action, raw_word    | taken when start & !busy
// result      | done, result_word, special_input | one cycle strobe on done
// config      | cfg_we, cfg_data                 | written when cfg_we
//
// One transaction per cycle; each result passes through four register stages
// (swap/select, leading-one, exponent math, shift/round/assemble).
// busy is always low: the receiver cannot stall, so nothing ever backs up.
// Synchronous reset clears stage valids, loads RESET_FORMAT (default IEEE).
module seismic_sample_format_converter_unit #(
  parameter logic [1:0] RESET_FORMAT = ssfc_pkg::FMT_RESET
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [31:0] raw_word,
  output logic        done,
  output logic [31:0] result_word,
  output logic        special_input,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data
);
  logic [1:0] sample_format;
  ssfc_pkg::stage_t s0;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= RESET_FORMAT;
    end else if (cfg_we) begin
      sample_format <= cfg_data;
    end
  end

  // Swap decode words into IBM/IEEE order and decide whether to convert.
  logic [31:0] dec_word;
  logic        dec_conv;
  always_comb begin
    dec_word = ssfc_pkg::swap32(raw_word);
    case (sample_format)
      ssfc_pkg::FMT_IBM:  dec_conv = 1'b1;
      ssfc_pkg::FMT_IEEE: dec_conv = 1'b0;
      default:            dec_conv = (dec_word[30:23] == 8'hFF);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else begin
      s0.valid <= start && !busy;
    end
    s0.action <= action;
    s0.word   <= action ? raw_word : dec_word;
    s0.conv   <= action ? (sample_format == ssfc_pkg::FMT_IBM) : dec_conv;
  end

  ssfc_core u_core (
    .clk(clk), .rst(rst), .in_stage(s0),
    .out_valid(done), .out_word(result_word), .out_special(special_input)
  );

  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("result missing");
  a_spec_enc: assert property (@(posedge clk) disable iff (rst)
    special_input |-> done)
    else $error("special without result");
endmodule

FILE: bench/tb_seismic_sample_format_converter_unit.sv
`timescale 1ns / 1ps
module tb_seismic_sample_format_converter_unit;

  // Format code three is not named in the package: decodes as auto, encodes as IEEE
  localparam logic [1:0] FMT_SPARE = 2'd3;
  localparam logic ACT_DECODE = 1'b0;
  localparam logic ACT_ENCODE = 1'b1;
  localparam int PHASE_ITEMS = 180;

  typedef struct {
    logic        act;
    logic [31:0] word;
  } sample_cmd_t;

  typedef struct {
    logic [31:0] word;
    logic        sat;
  } sample_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        action = 1'b0;
  logic [31:0] raw_word = '0;
  logic        done;
  logic [31:0] result_word;
  logic        special_input;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_data = '0;

  // Testbench copy of the format register
  logic [1:0]  fmt_shadow = ssfc_pkg::FMT_RESET;
  sample_cmd_t cmd_queue[$];
  sample_res_t conv_expected[$];
  sample_cmd_t cmd_now;
  sample_res_t res_now;
  int          gap_left = 0;
  bit          quiet = 1'b0;
  int          mismatches = 0;

  seismic_sample_format_converter_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .raw_word(raw_word), .done(done), .result_word(result_word),
    .special_input(special_input), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Byte reversal between file order and host order
  function automatic logic [31:0] flip_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic int top_bit(input logic [31:0] v);
    int p;
    p = -1;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = i;
    end
    return p;
  endfunction

  // IBM hex float to IEEE single, round to nearest even on underflow
  function automatic logic [31:0] hex_to_single(input logic [31:0] w);
    logic [31:0] sgn, frac, m, rem, half;
    int e, p, biased, s, sh;
    sgn = w & 32'h8000_0000;
    frac = w & 32'h00FF_FFFF;
    e = int'(w[30:24]);
    if (frac == 0) return sgn;
    p = top_bit(frac);
    biased = p + 4 * e - 4 * ssfc_pkg::IBM_BIAS - 24 + 127;
    if (biased >= 255) return sgn | 32'h7F80_0000;
    if (biased >= 1)
      return sgn | (32'(biased) << 23) | ((frac << (23 - p)) & 32'h007F_FFFF);
    s = 4 * e - 131;
    if (s >= 0) return sgn | (frac << s);
    sh = -s;
    if (sh >= 32) return sgn;
    m = frac >> sh;
    rem = frac & ((32'd1 << sh) - 1);
    half = 32'd1 << (sh - 1);
    if (rem > half || (rem == half && m[0])) m = m + 1;
    return sgn | m;
  endfunction

  // IEEE single to IBM hex float with truncated fraction; NaN/inf saturate
  function automatic logic [31:0] single_to_hex(input logic [31:0] w, output logic sat);
    logic [31:0] sgn, ex, sig, frac;
    int q, p, k, t;
    sat = 1'b0;
    sgn = w & 32'h8000_0000;
    ex = (w >> 23) & 32'hFF;
    sig = w & 32'h007F_FFFF;
    if (ex == 32'hFF) begin
      sat = 1'b1;
      return sgn | 32'h7FFF_FFFF;
    end
    if (ex == 0 && sig == 0) return 32'h0;
    if (ex == 0) ex = 1;
    else sig = sig | 32'h0080_0000;
    q = int'(ex) - 150;
    p = top_bit(sig);
    k = (p + q + 1000) / 4 - 250 + 1;
    t = q + 24 - 4 * k;
    frac = (t >= 0) ? (sig << t) : (sig >> (-t));
    return sgn | (32'(ssfc_pkg::IBM_BIAS + k) << 24) | (frac & 32'h00FF_FFFF);
  endfunction

  function automatic sample_res_t convert_sample(input logic act, input logic [31:0] w,
                                                 input logic [1:0] fmt);
    sample_res_t r;
    logic [31:0] v;
    logic        sat;
    r.sat = 1'b0;
    if (act == ACT_DECODE) begin
      v = flip_bytes(w);
      if (fmt == ssfc_pkg::FMT_IBM) r.word = hex_to_single(v);
      else if (fmt == ssfc_pkg::FMT_IEEE) r.word = v;
      else r.word = (v[30:23] == 8'hFF) ? hex_to_single(v) : v;
    end else begin
      if (fmt == ssfc_pkg::FMT_IBM) begin
        v = single_to_hex(w, sat);
        r.sat = sat;
      end else begin
        v = w;
      end
      r.word = flip_bytes(v);
    end
    return r;
  endfunction

  // Driver: hold the command until taken, then advance or idle for a burst
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        conv_expected = {conv_expected, convert_sample(action, raw_word, fmt_shadow)};
      if (start && busy) begin
        // hold the current transaction
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        cmd_now = cmd_queue.pop_front();
        start <= 1'b1;
        action <= cmd_now.act;
        raw_word <= cmd_now.word;
        if (!quiet && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 5);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest expected conversion
  always @(posedge clk) begin
    if (!rst && done) begin
      if (conv_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h special %b", result_word, special_input);
      end else begin
        res_now = conv_expected.pop_front();
        if (result_word !== res_now.word || special_input !== res_now.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b, got %h/%b", res_now.word, res_now.sat,
                     result_word, special_input);
        end
      end
    end
  end

  task automatic push_cmd(input logic act, input logic [31:0] host_word);
    sample_cmd_t c;
    c.act = act;
    // decode takes the word as loaded from the file, so store it byte-swapped
    c.word = (act == ACT_DECODE) ? flip_bytes(host_word) : host_word;
    cmd_queue = {cmd_queue, c};
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || start || conv_expected.size() != 0);
  endtask

  task automatic write_format(input logic [1:0] fmt);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= fmt;
    @(posedge clk);
    cfg_we <= 1'b0;
    fmt_shadow = fmt;
  endtask

  function automatic logic [31:0] hex_like();
    logic [6:0] ex;
    logic [23:0] fr;
    case ($urandom_range(0, 4))
      0: ex = 7'h00;
      1: ex = 7'h7F;
      2: ex = 7'($urandom_range(20, 45));
      default: ex = 7'($urandom);
    endcase
    fr = 24'($urandom) >> $urandom_range(0, 23);
    if ($urandom_range(0, 9) == 0) fr = '0;
    return {1'($urandom), ex, fr};
  endfunction

  function automatic logic [31:0] single_like();
    logic [7:0] ex;
    logic [22:0] man;
    case ($urandom_range(0, 5))
      0: ex = 8'h00;
      1: ex = 8'hFF;
      2: ex = 8'($urandom_range(1, 3));
      3: ex = 8'hFE;
      default: ex = 8'($urandom);
    endcase
    man = 23'($urandom) >> $urandom_range(0, 22);
    if ($urandom_range(0, 7) == 0) man = '0;
    return {1'($urandom), ex, man};
  endfunction

  initial begin
    logic [1:0] fmt_plan[8];
    logic [31:0] w;
    logic act;
    fmt_plan = '{ssfc_pkg::FMT_IBM, ssfc_pkg::FMT_IEEE, ssfc_pkg::FMT_AUTO, FMT_SPARE,
                 ssfc_pkg::FMT_IBM, ssfc_pkg::FMT_AUTO, ssfc_pkg::FMT_IEEE,
                 ssfc_pkg::FMT_IBM};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      // the pause before each write also drains every outstanding transaction
      wait_drained();
      write_format(fmt_plan[ph]);
      if (ph < 4) begin
        // IBM side: signed zeros with exponents, extremes, overflow, deep underflow
        push_cmd(ACT_DECODE, 32'h0000_0000);
        push_cmd(ACT_DECODE, 32'hFF00_0000);
        push_cmd(ACT_DECODE, 32'h7FFF_FFFF);
        push_cmd(ACT_DECODE, 32'hFFFF_FFFF);
        push_cmd(ACT_DECODE, 32'h4110_0000);
        push_cmd(ACT_DECODE, 32'h2180_0001);
        push_cmd(ACT_DECODE, 32'h0000_0001);
        push_cmd(ACT_DECODE, 32'h7F80_0000);
        push_cmd(ACT_DECODE, 32'hFFC0_0001);
        push_cmd(ACT_DECODE, 32'h3F80_0000);
        // IEEE side: zeros, infinities, NaN, subnormals, largest, one
        push_cmd(ACT_ENCODE, 32'h0000_0000);
        push_cmd(ACT_ENCODE, 32'h8000_0000);
        push_cmd(ACT_ENCODE, 32'h7F80_0000);
        push_cmd(ACT_ENCODE, 32'hFF80_0000);
        push_cmd(ACT_ENCODE, 32'h7FC0_0001);
        push_cmd(ACT_ENCODE, 32'h0000_0001);
        push_cmd(ACT_ENCODE, 32'h807F_FFFF);
        push_cmd(ACT_ENCODE, 32'h7F7F_FFFF);
        push_cmd(ACT_ENCODE, 32'h3F80_0000);
        push_cmd(ACT_ENCODE, 32'hFFFF_FFFF);
      end
      if (ph == 7) quiet = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        act = 1'($urandom);
        case ($urandom_range(0, 4))
          0: w = $urandom;
          1, 2: w = hex_like();
          default: w = single_like();
        endcase
        push_cmd(act, w);
      end
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("** seismic_sample_format_converter_unit: PASSED **");
    else $display("** seismic_sample_format_converter_unit: FAILED **");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** seismic_sample_format_converter_unit: FAILED **");
    $finish;
  end
endmodule

FILE: seismic_sample_format_converter_unit.f
design/ssfc_pkg.sv
design/ssfc_core.sv
design/seismic_sample_format_converter_unit.sv
bench/tb_seismic_sample_format_converter_unit.sv
